### hw/rtl/anp_pkg.sv
// ----------------------------------------------------------------------------
// anp_pkg
// Shared types, character codes and helpers for the ASCII number token parser.
// ----------------------------------------------------------------------------
`default_nettype none

package anp_pkg;

  // Default limit on numeric characters (sign, digits, point) in one token
  localparam int unsigned MaxNumericCharsDef = 16;

  localparam logic [7:0] ChPrintLo = 8'h20;
  localparam logic [7:0] ChPrintHi = 8'h7E;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChMinus   = 8'h2D;
  localparam logic [7:0] ChPoint   = 8'h2E;

  localparam logic [31:0] MagLimitPos = 32'h7FFF_FFFF;
  localparam logic [31:0] MagLimitNeg = 32'h8000_0000;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_DEC   = 2'd1,
    KIND_TEXT  = 2'd2,
    KIND_EMPTY = 2'd3
  } token_kind_e;

  // Summary of the token collected so far
  typedef struct packed {
    logic [31:0] magnitude;
    logic        negative;
    logic [4:0]  frac_count;
    logic        has_numeric;
    logic        could_int;
    logic        could_dec;
    logic        saturated;
    logic [15:0] print_count;
  } token_sum_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= ChPrintLo) && (b <= ChPrintHi);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= ChZero) && (b <= ChNine);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/anp_token_state.sv
// ----------------------------------------------------------------------------
// anp_token_state
// Per-token state: classifies each byte and accumulates the decimal value.
// ----------------------------------------------------------------------------
`default_nettype none

module anp_token_state
  import anp_pkg::*;
#(
  parameter int unsigned MaxNumericChars = MaxNumericCharsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  output token_sum_t      tok_o
);

  localparam int unsigned CntW = $clog2(MaxNumericChars + 1);

  logic [31:0]     mag_q, mag_d;
  logic            neg_q, neg_d;
  logic            point_q, point_d;
  logic [4:0]      frac_q, frac_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            cint_q, cint_d;
  logic            cdec_q, cdec_d;
  logic            sat_q, sat_d;
  logic [15:0]     pcnt_q, pcnt_d;

  logic        printable;
  logic        digit;
  logic        room;
  logic [3:0]  dval;
  logic [35:0] mag_x10;
  logic [35:0] limit;

  assign printable = is_printable(byte_i);
  assign digit     = is_digit(byte_i);
  assign room      = cnt_q < CntW'(MaxNumericChars);
  assign dval      = byte_i[3:0];
  assign limit     = {4'b0, (neg_q ? MagLimitNeg : MagLimitPos)};
  assign mag_x10   = {1'b0, mag_q, 3'b0} + {3'b0, mag_q, 1'b0} + {32'b0, dval};

  always_comb begin
    mag_d   = mag_q;
    neg_d   = neg_q;
    point_d = point_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    cint_d  = cint_q;
    cdec_d  = cdec_q;
    sat_d   = sat_q;
    pcnt_d  = pcnt_q;
    if (step_i) begin
      if (printable) begin
        if (room && digit) begin
          if (mag_x10 > limit) begin
            mag_d = limit[31:0];
            sat_d = 1'b1;
          end else begin
            mag_d = mag_x10[31:0];
          end
          if (point_q) frac_d = frac_q + 5'd1;
          cnt_d = cnt_q + CntW'(1);
        end else if (room && (cnt_q == '0) && (byte_i == ChMinus)) begin
          neg_d = 1'b1;
          cnt_d = cnt_q + CntW'(1);
        end else if (room && (byte_i == ChPoint) && !point_q) begin
          point_d = 1'b1;
          cint_d  = 1'b0;
          cnt_d   = cnt_q + CntW'(1);
        end else begin
          cint_d = 1'b0;
          cdec_d = 1'b0;
        end
        if (pcnt_q != 16'hFFFF) pcnt_d = pcnt_q + 16'd1;
      end else begin
        // terminator: the result is taken from the current state, then clear
        mag_d   = '0;
        neg_d   = 1'b0;
        point_d = 1'b0;
        frac_d  = '0;
        cnt_d   = '0;
        cint_d  = 1'b1;
        cdec_d  = 1'b1;
        sat_d   = 1'b0;
        pcnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q   <= '0;
      neg_q   <= 1'b0;
      point_q <= 1'b0;
      frac_q  <= '0;
      cnt_q   <= '0;
      cint_q  <= 1'b1;
      cdec_q  <= 1'b1;
      sat_q   <= 1'b0;
      pcnt_q  <= '0;
    end else begin
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      point_q <= point_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
      cint_q  <= cint_d;
      cdec_q  <= cdec_d;
      sat_q   <= sat_d;
      pcnt_q  <= pcnt_d;
    end
  end

  always_comb begin
    tok_o.magnitude   = mag_q;
    tok_o.negative    = neg_q;
    tok_o.frac_count  = frac_q;
    tok_o.has_numeric = (cnt_q != '0);
    tok_o.could_int   = cint_q;
    tok_o.could_dec   = cdec_q;
    tok_o.saturated   = sat_q;
    tok_o.print_count = pcnt_q;
  end

endmodule

`default_nettype wire

### hw/rtl/ascii_number_token_parser.sv
// ----------------------------------------------------------------------------
// ascii_number_token_parser
// Parses a byte stream into tokens and reports each as integer, decimal,
// text or empty, with a signed saturated mantissa and fraction digit count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel rx_byte_i / in_valid_i / in_ready_o takes one byte per
//   transfer. Printable bytes (0x20..0x7E) extend the current token and give
//   no result. Any other byte ends the token and produces one result on the
//   output channel out_valid_o / out_ready_i, with value
//   mantissa_o / 10^fraction_digits_o.
//   Throughput is one byte per cycle while in_ready_o is high: the per-byte
//   multiply-by-ten accumulate and flag update sit between the token state
//   registers and the input port. A result appears on the output register
//   in the cycle after its terminating byte is taken.
//   The output register holds while out_ready_i is low; the input then
//   stalls only while a held result is not being taken in the same cycle.
//   Reset empties the output register and returns the token state to an
//   empty token.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_number_token_parser
  import anp_pkg::*;
#(
  parameter int unsigned MaxNumericChars = MaxNumericCharsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              token_kind_o,
  output logic signed [31:0]      mantissa_o,
  output logic [4:0]              fraction_digits_o,
  output logic                    overflow_o,
  output logic [15:0]             text_length_o
);

  token_sum_t  tok;
  logic        in_xfer;
  logic        term_xfer;
  logic        out_valid_q, out_valid_d;
  token_kind_e kind_q, kind_d;
  logic [31:0] mant_q, mant_d;
  logic [4:0]  frac_q, frac_d;
  logic        ovf_q, ovf_d;
  logic [15:0] tlen_q, tlen_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign term_xfer  = in_xfer && !is_printable(rx_byte_i);

  anp_token_state #(
    .MaxNumericChars(MaxNumericChars)
  ) u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_xfer),
    .byte_i (rx_byte_i),
    .tok_o  (tok)
  );

  always_comb begin
    if (tok.has_numeric && tok.could_int) begin
      kind_d = KIND_INT;
    end else if (tok.has_numeric && tok.could_dec) begin
      kind_d = KIND_DEC;
    end else if (tok.print_count != '0) begin
      kind_d = KIND_TEXT;
    end else begin
      kind_d = KIND_EMPTY;
    end
    mant_d = '0;
    frac_d = '0;
    ovf_d  = 1'b0;
    if ((kind_d == KIND_INT) || (kind_d == KIND_DEC)) begin
      mant_d = tok.negative ? (32'd0 - tok.magnitude) : tok.magnitude;
      ovf_d  = tok.saturated;
      if (kind_d == KIND_DEC) frac_d = tok.frac_count;
    end
    tlen_d = tok.print_count;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (term_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload loads only on a terminating transfer
  always_ff @(posedge clk_i) begin
    if (term_xfer) begin
      kind_q <= kind_d;
      mant_q <= mant_d;
      frac_q <= frac_d;
      ovf_q  <= ovf_d;
      tlen_q <= tlen_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign token_kind_o      = kind_q;
  assign mantissa_o        = mant_q;
  assign fraction_digits_o = frac_q;
  assign overflow_o        = ovf_q;
  assign text_length_o     = tlen_q;

  a_term_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_xfer |=> out_valid_o)
    else $error("terminating byte did not produce a result");

  a_non_numeric_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((token_kind_o == KIND_TEXT) || (token_kind_o == KIND_EMPTY)))
      |-> (mantissa_o == '0 && fraction_digits_o == '0 && !overflow_o))
    else $error("text or empty token carries numeric fields");

  a_int_no_frac : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == KIND_INT)) |-> (fraction_digits_o == '0))
    else $error("integer token with fraction digits");

  a_empty_no_text : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (token_kind_o == KIND_EMPTY)) |-> (text_length_o == '0))
    else $error("empty token with nonzero length");

endmodule

`default_nettype wire
